// File: hw/rtl/memory_with_region_protection_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the region-protected memory
// Shared forms for the concurrent checks written at the end of mwrp_ctrl.
// ---------------------------------------------------------------------------
`ifndef MEMORY_WITH_REGION_PROTECTION_DEFINES_SVH
`define MEMORY_WITH_REGION_PROTECTION_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MWRP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mwrp assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MWRP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mwrp assertion failed");

`endif

// File: hw/rtl/mwrp_pkg.sv
// ---------------------------------------------------------------------------
// mwrp_pkg
// Types, codes and defaults shared by the region-protected memory modules.
// ---------------------------------------------------------------------------
package mwrp_pkg;

  localparam int MEM_BYTES_DEF   = 65536;
  localparam int MAX_REGIONS_DEF = 64;
  localparam int PAIR_BYTES      = 8;

  localparam logic       CMD_READ  = 1'b0;
  localparam logic       CMD_WRITE = 1'b1;

  localparam logic [1:0] SIZE_BYTE = 2'b00;
  localparam logic [1:0] SIZE_HALF = 2'b01;
  localparam logic [1:0] SIZE_WORD = 2'b10;
  localparam logic [1:0] SIZE_BAD  = 2'b11;

  localparam logic [1:0] ERR_OK    = 2'b00;
  localparam logic [1:0] ERR_SIZE  = 2'b01;
  localparam logic [1:0] ERR_RANGE = 2'b10;

  localparam logic [1:0] LVL_KERNEL = 2'b00;
  localparam logic [1:0] LVL_DRIVER = 2'b01;
  localparam logic [1:0] LVL_USER   = 2'b10;

  localparam logic [2:0] CFG_LEVEL        = 3'd0;
  localparam logic [2:0] CFG_USER_BASE    = 3'd1;
  localparam logic [2:0] CFG_DRIVER_BASE  = 3'd2;
  localparam logic [2:0] CFG_PCI_BASE     = 3'd3;
  localparam logic [2:0] CFG_PCI_LIMIT    = 3'd4;

  typedef struct packed {
    logic        cmd;
    logic [31:0] addr;
    logic [1:0]  size;
    logic [31:0] wdata;
  } in_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        allowed;
    logic [1:0]  error;
  } out_t;

  typedef struct packed {
    logic [1:0]  level;
    logic [31:0] user_table_base;
    logic [31:0] driver_table_base;
    logic [31:0] pci_window_base;
    logic [31:0] pci_window_limit;
  } cfg_t;

  typedef struct packed {
    logic       en;
    logic [3:0] be;
  } mem_wr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_START,
    S_LO,
    S_HI,
    S_TEND,
    S_ACCESS,
    S_ACC2,
    S_DONE
  } state_t;

  // Byte lanes touched by an access of the given size, from lane 0 up.
  function automatic logic [3:0] byte_mask(logic [1:0] size);
    logic [3:0] m;
    case (size)
      SIZE_BYTE: m = 4'b0001;
      SIZE_HALF: m = 4'b0011;
      SIZE_WORD: m = 4'b1111;
      default:   m = 4'b0000;
    endcase
    return m;
  endfunction

  // Offset of the last byte of an access from its first byte.
  function automatic logic [1:0] last_offset(logic [1:0] size);
    logic [1:0] o;
    case (size)
      SIZE_BYTE: o = 2'd0;
      SIZE_HALF: o = 2'd1;
      default:   o = 2'd3;
    endcase
    return o;
  endfunction

endpackage

// File: hw/rtl/mwrp_mem.sv
// ---------------------------------------------------------------------------
// mwrp_mem
// Word-wide storage with byte-lane writes and two registered read ports, so
// that any four consecutive bytes can be fetched from two adjacent rows.
// ---------------------------------------------------------------------------
module mwrp_mem
  import mwrp_pkg::*;
#(
  parameter int ROWS = MEM_BYTES_DEF / 4,
  parameter int RW   = $clog2(ROWS)
) (
  input  logic          clk,
  input  mem_wr_t       wr,
  input  logic [RW-1:0] wa,
  input  logic [31:0]   wd,
  input  logic [RW-1:0] ra0,
  input  logic [RW-1:0] ra1,
  output logic [31:0]   rd0,
  output logic [31:0]   rd1
);

  logic [31:0] ram [ROWS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      for (int l = 0; l < 4; l++) begin
        if (wr.be[l]) begin
          ram[wa][8*l +: 8] <= wd[8*l +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd0 <= ram[ra0];
    rd1 <= ram[ra1];
  end

endmodule

// File: hw/rtl/mwrp_ctrl.sv
// ---------------------------------------------------------------------------
// mwrp_ctrl
// Sequencer: range check, region table walks through the memory, the data
// access itself, and the result register.
// ---------------------------------------------------------------------------
`include "memory_with_region_protection_defines.svh"

module mwrp_ctrl
  import mwrp_pkg::*;
#(
  parameter int MEM_BYTES   = MEM_BYTES_DEF,
  parameter int MAX_REGIONS = MAX_REGIONS_DEF,
  parameter int RW          = $clog2((MEM_BYTES + 3) / 4)
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_t           in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output out_t          out_data,
  output mem_wr_t       wr,
  output logic [RW-1:0] wa,
  output logic [31:0]   wd,
  output logic [RW-1:0] ra0,
  output logic [RW-1:0] ra1,
  input  logic [31:0]   rd0,
  input  logic [31:0]   rd1
);

  localparam int KW = $clog2(MAX_REGIONS + 1);
  localparam logic [32:0] MEM_END = 33'(MEM_BYTES);

  state_t        state, state_next;
  logic          cmd_r;
  logic [31:0]   addr_r;
  logic [1:0]    size_r;
  logic [31:0]   wdata_r;
  logic [31:0]   last_r;
  logic [1:0]    err_r;
  logic          ok_r;
  logic          tsel_r;        // 0 user table, 1 driver table
  logic [32:0]   p_r;
  logic [KW-1:0] k_r;
  logic [31:0]   lo_r;
  logic [31:0]   rdata_r;
  logic [1:0]    off_r;

  logic [32:0]   last_full;
  logic [1:0]    err_now;
  logic [31:0]   rd_addr;
  logic [63:0]   win;
  logic [31:0]   word;
  logic          start_ok;
  logic          pair_end;
  logic          pair_hit;
  logic          more;
  logic          pci_hit;
  logic [3:0]    lane_mask;
  logic [7:0]    be8;
  logic [63:0]   wwide;
  logic [RW-1:0] arow;
  logic          out_free;

  // Range check on the latched request.
  assign last_full = {1'b0, addr_r} + {31'd0, last_offset(size_r)};
  always_comb begin
    if (size_r == SIZE_BAD) begin
      err_now = ERR_SIZE;
    end else if (last_full >= MEM_END) begin
      err_now = ERR_RANGE;
    end else begin
      err_now = ERR_OK;
    end
  end

  // Four bytes starting anywhere come from two adjacent rows.
  assign win  = {rd1, rd0} >> {off_r, 3'b000};
  assign word = win[31:0];

  assign start_ok = (p_r + 33'd8) < MEM_END;
  assign pair_end = lo_r >= word;
  assign pair_hit = (lo_r <= addr_r) && (last_r < word);
  assign more     = ((k_r + KW'(1)) < KW'(MAX_REGIONS)) &&
                    ((p_r + 33'(2 * PAIR_BYTES)) < MEM_END);
  assign pci_hit  = (cfg.pci_window_base <= addr_r) && (last_r < cfg.pci_window_limit);

  assign lane_mask = byte_mask(size_r);
  assign be8   = {4'b0000, lane_mask} << addr_r[1:0];
  assign wwide = {32'd0, wdata_r} << {addr_r[1:0], 3'b000};
  assign arow  = addr_r[RW+1:2];

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_CHECK;
      S_CHECK: begin
        if (err_now != ERR_OK) begin
          state_next = S_DONE;
        end else if (cfg.level == LVL_DRIVER || cfg.level == LVL_USER) begin
          state_next = S_START;
        end else begin
          state_next = S_ACCESS;
        end
      end
      S_START:  state_next = start_ok ? S_LO : S_TEND;
      S_LO:     state_next = S_HI;
      S_HI: begin
        if (pair_end) begin
          state_next = S_TEND;
        end else if (pair_hit) begin
          state_next = S_ACCESS;
        end else if (more) begin
          state_next = S_LO;
        end else begin
          state_next = S_TEND;
        end
      end
      S_TEND: begin
        if (!tsel_r && cfg.level == LVL_DRIVER) begin
          state_next = S_START;
        end else begin
          state_next = S_ACCESS;
        end
      end
      S_ACCESS: state_next = S_ACC2;
      S_ACC2:   state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Memory port control and the in_stall handshake output.
  always_comb begin
    in_stall = (state != S_IDLE);
    wr       = '0;
    wa       = arow;
    wd       = wwide[31:0];
    unique case (state)
      S_START:  rd_addr = p_r[31:0];
      S_LO:     rd_addr = p_r[31:0] + 32'd4;
      S_HI:     rd_addr = p_r[31:0] + 32'(PAIR_BYTES);
      default:  rd_addr = addr_r;
    endcase
    if (state == S_ACCESS && cmd_r == CMD_WRITE) begin
      wr.en = 1'b1;
      wr.be = be8[3:0];
    end else if (state == S_ACC2 && cmd_r == CMD_WRITE) begin
      wr.en = |be8[7:4];
      wr.be = be8[7:4];
      wa    = arow + RW'(1);
      wd    = wwide[63:32];
    end
  end

  assign ra0 = rd_addr[RW+1:2];
  assign ra1 = rd_addr[RW+1:2] + RW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    off_r <= rd_addr[1:0];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_r   <= in_data.cmd;
          addr_r  <= in_data.addr;
          size_r  <= in_data.size;
          wdata_r <= in_data.wdata;
        end
      end
      S_CHECK: begin
        last_r  <= last_full[31:0];
        err_r   <= err_now;
        ok_r    <= (err_now == ERR_OK) && (cfg.level == LVL_KERNEL);
        rdata_r <= '0;
        tsel_r  <= 1'b0;
        p_r     <= {1'b0, cfg.user_table_base};
        k_r     <= '0;
      end
      S_LO: lo_r <= word;
      S_HI: begin
        if (!pair_end && pair_hit) begin
          ok_r <= 1'b1;
        end
        p_r <= p_r + 33'(PAIR_BYTES);
        k_r <= k_r + KW'(1);
      end
      S_TEND: begin
        if (!tsel_r && cfg.level == LVL_DRIVER) begin
          tsel_r <= 1'b1;
          p_r    <= {1'b0, cfg.driver_table_base};
          k_r    <= '0;
        end else if (tsel_r) begin
          ok_r <= pci_hit;
        end
      end
      S_ACC2: begin
        if (cmd_r == CMD_READ) begin
          for (int l = 0; l < 4; l++) begin
            rdata_r[8*l +: 8] <= lane_mask[l] ? word[8*l +: 8] : 8'd0;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_data.rdata   <= rdata_r;
          out_data.allowed <= ok_r;
          out_data.error   <= err_r;
        end
      end
      default: ;
    endcase
  end

  `MWRP_ASSERT_IMP(a_err_clean, clk, rst,
                   out_valid && out_data.error != ERR_OK,
                   !out_data.allowed && out_data.rdata == 32'd0)
  `MWRP_ASSERT_IMP(a_wr_in_access, clk, rst, wr.en,
                   (state == S_ACCESS || state == S_ACC2) && cmd_r == CMD_WRITE)
  `MWRP_ASSERT_IMP(a_pair_bound, clk, rst, state == S_LO || state == S_HI,
                   k_r < KW'(MAX_REGIONS))
  `MWRP_ASSERT_NXT(a_accept_check, clk, rst, in_valid && !in_stall,
                   state == S_CHECK)

endmodule

// File: hw/rtl/memory_with_region_protection.sv
// ---------------------------------------------------------------------------
// memory_with_region_protection
// Byte-addressed little-endian memory with a privilege-dependent region check.
// ---------------------------------------------------------------------------
// Usage: a request word (cmd, addr, size, wdata) enters on in_valid/in_stall;
// one result word (rdata, allowed, error) leaves on out_valid/out_stall for
// every request. Reads and writes of 1, 2 or 4 bytes at any byte address.
// Kernel level and level 3 go straight to the data access and errors straight
// to the result; user level first walks the user region table and driver
// level the user and then the driver table, one (start, end) pair at a time.
// The walk fetches one 32-bit word per cycle from the memory.
// One request is in flight at a time; the next is taken the cycle after the
// result is loaded into the output register, so a stalled receiver only
// holds the block once a second result is ready to replace the first.
// Configuration writes take effect at once; the user must make them only while idle, as the block does not enforce it.
// Reset (synchronous, active high) clears the sequencer state, the
// configuration registers and the output valid; memory contents are
// undefined until written, with no clearing pass.
// ---------------------------------------------------------------------------
module memory_with_region_protection
  import mwrp_pkg::*;
#(
  parameter int MEM_BYTES   = MEM_BYTES_DEF,
  parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int ROWS = (MEM_BYTES + 3) / 4;
  localparam int RW   = $clog2(ROWS);

  cfg_t          cfg;
  mem_wr_t       wr;
  logic [RW-1:0] wa;
  logic [31:0]   wd;
  logic [RW-1:0] ra0;
  logic [RW-1:0] ra1;
  logic [31:0]   rd0;
  logic [31:0]   rd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEVEL:       cfg.level             <= cfg_data[1:0];
        CFG_USER_BASE:   cfg.user_table_base   <= cfg_data;
        CFG_DRIVER_BASE: cfg.driver_table_base <= cfg_data;
        CFG_PCI_BASE:    cfg.pci_window_base   <= cfg_data;
        CFG_PCI_LIMIT:   cfg.pci_window_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  mwrp_ctrl #(
    .MEM_BYTES   (MEM_BYTES),
    .MAX_REGIONS (MAX_REGIONS),
    .RW          (RW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .wr        (wr),
    .wa        (wa),
    .wd        (wd),
    .ra0       (ra0),
    .ra1       (ra1),
    .rd0       (rd0),
    .rd1       (rd1)
  );

  mwrp_mem #(
    .ROWS (ROWS),
    .RW   (RW)
  ) u_mem (
    .clk (clk),
    .wr  (wr),
    .wa  (wa),
    .wd  (wd),
    .ra0 (ra0),
    .ra1 (ra1),
    .rd0 (rd0),
    .rd1 (rd1)
  );

endmodule
